// ===== hw/rtl/bftd_pkg.sv =====
// Shared constants and types of the box filter thumbnail downscaler.
`timescale 1ns / 1ps
package bftd_pkg;
    localparam int THUMB_COLS = 32;
    localparam int THUMB_ROWS = 24;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W   = 8;
    localparam int TC_W    = 5;
    localparam int TR_W    = 5;
    localparam int SUM_W   = 23;
    localparam int CNT_W   = 15;
    localparam int BLK_W   = 8;
    localparam int POS_W   = 12;
    localparam int REG_W   = 13;
    localparam int IDX_W   = 8;
    localparam int QUO_W   = 8;
    localparam int NCH     = 3;

    localparam int QDEPTH  = 4;
    localparam int QIDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 8'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 8'd1;

    // one in-range source pixel, classified by the front part
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic [TC_W-1:0]  tc;
        logic [TR_W-1:0]  tr;
        logic             emit;
        logic             last;
    } t_pix;
endpackage

// ===== hw/rtl/box_filter_thumbnail_downscale_top.sv =====
// Top level of the box filter thumbnail downscaler.
`timescale 1ns / 1ps
// Takes a raster-order RGB pixel stream and returns a 32 by 24 thumbnail, one
// request per block, in block-completion order; the final thumbnail pixel has
// tlast set. One source pixel is accepted per cycle while the output side keeps
// up: the column sums update by read-modify-write and the average comes from an
// eight-stage pipelined divider (one quotient bit per stage). A four-entry queue
// between the front counters and the back sums absorbs short output stalls.
// Writing image_width (index 0) or image_height (index 1) restarts the image;
// write them only while no pixel is in flight.
module box_filter_thumbnail_downscale_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [23:0]                 s_axis_tdata,   // red_in, green_in, blue_in
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [39:0]                 m_axis_tdata,   // red_out, green_out, blue_out,
                                                        // thumb_col, thumb_row, zero pad
    output logic                        m_axis_tlast,   // last_of_image
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bftd_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [bftd_pkg::REG_W-1:0]  i_cfg_data
);
    import bftd_pkg::*;

    logic             restart, full, empty, push, pop;
    logic [CNT_W-1:0] count;
    t_pix             q_in, q_out;
    logic [PIX_W-1:0] red, green, blue;
    logic [TC_W-1:0]  col;
    logic [TR_W-1:0]  row;

    assign o_cfg_ready = 1'b1;

    bftd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_restart   (restart),
        .o_count     (count),
        .i_pix_valid (s_axis_tvalid),
        .i_pix_data  (s_axis_tdata),
        .o_pix_ready (s_axis_tready),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (q_in)
    );

    bftd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (q_out)
    );

    bftd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_count   (count),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_entry   (q_out),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_red     (red),
        .o_green   (green),
        .o_blue    (blue),
        .o_col     (col),
        .o_row     (row),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, row, col, blue, green, red};
endmodule

// ===== hw/rtl/bftd_front.sv =====
// Front part: configuration registers, raster position counters and pixel classification.
`timescale 1ns / 1ps
module bftd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bftd_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [bftd_pkg::REG_W-1:0]    i_cfg_data,
    output logic                          o_restart,
    output logic [bftd_pkg::CNT_W-1:0]    o_count,
    input  logic                          i_pix_valid,
    input  logic [3*bftd_pkg::PIX_W-1:0]  i_pix_data,
    output logic                          o_pix_ready,
    input  logic                          i_full,
    output logic                          o_push,
    output bftd_pkg::t_pix                o_entry
);
    import bftd_pkg::*;

    logic [REG_W-1:0] r_w, r_h, n_w_cl, n_h_cl;
    logic [BLK_W-1:0] r_bw, r_bh, n_bh;
    logic [CNT_W-1:0] r_count;
    logic [2*BLK_W-1:0] count_prod;
    logic [19:0]      bh_prod;

    logic [POS_W-1:0] r_col, r_row;
    logic [6:0]       r_bcol;
    logic [BLK_W-1:0] r_brow;
    logic [TC_W:0]    r_tc;
    logic [TR_W:0]    r_tr;

    logic wr_w, wr_h, accept, in_range, col_wrap, row_wrap, bcol_end, brow_end;

    assign wr_w      = i_cfg_valid && (i_cfg_index == REG_WIDTH);
    assign wr_h      = i_cfg_valid && (i_cfg_index == REG_HEIGHT);
    assign o_restart = wr_w || wr_h;

    always_comb begin
        if (i_cfg_data < REG_W'(THUMB_COLS))      n_w_cl = REG_W'(THUMB_COLS);
        else if (i_cfg_data > REG_W'(MAX_WIDTH))  n_w_cl = REG_W'(MAX_WIDTH);
        else                                      n_w_cl = i_cfg_data;
        if (i_cfg_data < REG_W'(THUMB_ROWS))      n_h_cl = REG_W'(THUMB_ROWS);
        else if (i_cfg_data > REG_W'(MAX_HEIGHT)) n_h_cl = REG_W'(MAX_HEIGHT);
        else                                      n_h_cl = i_cfg_data;
        // h / 24 = (h / 8) / 3, with 683 / 2048 as the reciprocal of 3
        bh_prod = 20'(n_h_cl[REG_W-1:3]) * 20'd683;
        n_bh    = bh_prod[18:11];
    end

    assign count_prod = r_bw * r_bh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w     <= REG_W'(THUMB_COLS);
            r_h     <= REG_W'(THUMB_ROWS);
            r_bw    <= BLK_W'(1);
            r_bh    <= BLK_W'(1);
            r_count <= CNT_W'(1);
        end else begin
            if (wr_w) begin
                r_w  <= n_w_cl;
                r_bw <= n_w_cl[REG_W-1:5];
            end
            if (wr_h) begin
                r_h  <= n_h_cl;
                r_bh <= n_bh;
            end
            r_count <= count_prod[CNT_W-1:0];
        end
    end

    assign o_count = r_count;

    assign o_pix_ready = !i_full;
    assign accept      = i_pix_valid && !i_full;
    assign in_range    = !r_tc[TC_W] && (r_tr < (TR_W+1)'(THUMB_ROWS));
    assign bcol_end    = ({1'b0, r_bcol} == (r_bw - BLK_W'(1)));
    assign brow_end    = (r_brow == (r_bh - BLK_W'(1)));
    assign col_wrap    = ({1'b0, r_col} + REG_W'(1)) >= r_w;
    assign row_wrap    = ({1'b0, r_row} + REG_W'(1)) >= r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_restart) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bcol <= '0;
            r_brow <= '0;
            r_tc   <= '0;
            r_tr   <= '0;
        end else if (accept) begin
            if (col_wrap) begin
                r_col  <= '0;
                r_bcol <= '0;
                r_tc   <= '0;
                if (row_wrap) begin
                    r_row  <= '0;
                    r_brow <= '0;
                    r_tr   <= '0;
                end else begin
                    r_row <= r_row + POS_W'(1);
                    if (brow_end) begin
                        r_brow <= '0;
                        r_tr   <= r_tr + (TR_W+1)'(1);
                    end else begin
                        r_brow <= r_brow + BLK_W'(1);
                    end
                end
            end else begin
                r_col <= r_col + POS_W'(1);
                if (bcol_end) begin
                    r_bcol <= '0;
                    r_tc   <= r_tc + (TC_W+1)'(1);
                end else begin
                    r_bcol <= r_bcol + 7'd1;
                end
            end
        end
    end

    // remainder columns and rows never reach the queue
    assign o_push = accept && in_range;

    always_comb begin
        o_entry.red   = i_pix_data[PIX_W-1:0];
        o_entry.green = i_pix_data[2*PIX_W-1:PIX_W];
        o_entry.blue  = i_pix_data[3*PIX_W-1:2*PIX_W];
        o_entry.tc    = r_tc[TC_W-1:0];
        o_entry.tr    = r_tr[TR_W-1:0];
        o_entry.emit  = bcol_end && brow_end;
        o_entry.last  = (r_tc == (TC_W+1)'(THUMB_COLS - 1)) &&
                        (r_tr == (TR_W+1)'(THUMB_ROWS - 1));
    end
endmodule

// ===== hw/rtl/bftd_queue.sv =====
// Short request queue between the front and back parts.
`timescale 1ns / 1ps
module bftd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bftd_pkg::t_pix i_entry,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bftd_pkg::t_pix o_entry
);
    import bftd_pkg::*;

    t_pix              r_mem [QDEPTH];
    logic [QIDX_W-1:0] r_wr, r_rd;
    logic [QIDX_W:0]   r_fill;
    logic              do_push, do_pop;

    assign o_full  = (r_fill == (QIDX_W+1)'(QDEPTH));
    assign o_empty = (r_fill == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + QIDX_W'(1);
            if (do_pop)  r_rd <= r_rd + QIDX_W'(1);
            r_fill <= r_fill + (QIDX_W+1)'(do_push) - (QIDX_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_entry;
    end
endmodule

// ===== hw/rtl/bftd_back.sv =====
// Back part: per-column channel sums and an eight-stage pipelined divider.
`timescale 1ns / 1ps
module bftd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_restart,
    input  logic [bftd_pkg::CNT_W-1:0]  i_count,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  bftd_pkg::t_pix              i_entry,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bftd_pkg::PIX_W-1:0]  o_red,
    output logic [bftd_pkg::PIX_W-1:0]  o_green,
    output logic [bftd_pkg::PIX_W-1:0]  o_blue,
    output logic [bftd_pkg::TC_W-1:0]   o_col,
    output logic [bftd_pkg::TR_W-1:0]   o_row,
    output logic                        o_last
);
    import bftd_pkg::*;

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] rem;
        logic [NCH-1:0][QUO_W-1:0] quo;
        logic [TC_W-1:0]           tc;
        logic [TR_W-1:0]           tr;
        logic                      last;
    } t_div;

    logic [SUM_W-1:0]      r_sums [NCH][THUMB_COLS];
    logic [THUMB_COLS-1:0] r_sum_vld;
    logic [SUM_W-1:0]      acc [NCH];
    logic [PIX_W-1:0]      pix [NCH];

    t_div       r_stg [QUO_W+1];
    t_div       n_stg [QUO_W];
    logic [QUO_W:0] r_vld;
    logic       en;

    assign en    = !r_vld[QUO_W] || i_ready;
    assign o_pop = !i_empty && en;

    always_comb begin
        pix[0] = i_entry.red;
        pix[1] = i_entry.green;
        pix[2] = i_entry.blue;
        for (int ch = 0; ch < NCH; ch++) begin
            // a column whose valid bit is clear holds zero
            acc[ch] = (r_sum_vld[i_entry.tc] ? r_sums[ch][i_entry.tc] : '0)
                      + SUM_W'(pix[ch]);
        end
    end

    // restoring division, one quotient bit per stage; the average never exceeds 255
    always_comb begin
        logic [SUM_W-1:0] dv;
        dv = '0;
        for (int k = 0; k < QUO_W; k++) begin
            n_stg[k] = r_stg[k];
            for (int ch = 0; ch < NCH; ch++) begin
                dv = SUM_W'(i_count) << (QUO_W - 1 - k);
                if (r_stg[k].rem[ch] >= dv) begin
                    n_stg[k].rem[ch]              = r_stg[k].rem[ch] - dv;
                    n_stg[k].quo[ch][QUO_W-1-k]   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= '0;
            r_vld     <= '0;
        end else begin
            if (i_restart) begin
                r_sum_vld <= '0;
            end else if (o_pop) begin
                r_sum_vld[i_entry.tc] <= !i_entry.emit;
            end
            if (en) r_vld <= {r_vld[QUO_W-1:0], o_pop && i_entry.emit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_entry.emit) begin
            for (int ch = 0; ch < NCH; ch++) r_sums[ch][i_entry.tc] <= acc[ch];
        end
        if (en) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_stg[0].rem[ch] <= acc[ch];
                r_stg[0].quo[ch] <= '0;
            end
            r_stg[0].tc   <= i_entry.tc;
            r_stg[0].tr   <= i_entry.tr;
            r_stg[0].last <= i_entry.last;
            for (int k = 0; k < QUO_W; k++) r_stg[k+1] <= n_stg[k];
        end
    end

    assign o_valid = r_vld[QUO_W];
    assign o_red   = r_stg[QUO_W].quo[0];
    assign o_green = r_stg[QUO_W].quo[1];
    assign o_blue  = r_stg[QUO_W].quo[2];
    assign o_col   = r_stg[QUO_W].tc;
    assign o_row   = r_stg[QUO_W].tr;
    assign o_last  = r_stg[QUO_W].last;
endmodule

// ===== hw/rtl/bftd_checker.sv =====
// Port-level assertions for the thumbnail downscaler, bound to the top level.
`timescale 1ns / 1ps
module bftd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import bftd_pkg::*;

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[28:24] == 5'(THUMB_COLS - 1) &&
            m_axis_tdata[33:29] == 5'(THUMB_ROWS - 1))
        else $error("tlast away from the final thumbnail pixel");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            m_axis_tdata[28:24] != 5'(THUMB_COLS - 1) ||
            m_axis_tdata[33:29] != 5'(THUMB_ROWS - 1))
        else $error("final thumbnail pixel without tlast");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[33:29] < 5'(THUMB_ROWS) &&
            m_axis_tdata[39:34] == 6'd0)
        else $error("thumbnail row out of range or pad bits set");
endmodule

bind box_filter_thumbnail_downscale_top bftd_checker u_bftd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
